// ===== rtl/core/csbt_pkg.sv =====
// Package for the checked byte memory with bandwidth timing.
// Holds the item types, memory geometry, command and register codes.
// No dependencies; every other file in rtl/core uses it by scoped names.
package csbt_pkg;

    // Memory geometry.
    localparam int MEM_BYTES        = 65536;
    localparam int MAX_ACCESS_BYTES = 8;
    localparam int WORDS            = (MEM_BYTES + 7) / 8;
    localparam int WORD_AW          = $clog2(WORDS);
    localparam logic [7:0] FILL_BYTE = 8'h57;

    // Width of the cycle counters.
    localparam int CYC_W = 48;

    // Command codes.
    localparam logic [1:0] CMD_READ      = 2'd0;
    localparam logic [1:0] CMD_WRITE     = 2'd1;
    localparam logic [1:0] CMD_POWER_OFF = 2'd2;
    localparam logic [1:0] CMD_POWER_ON  = 2'd3;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_CHECK_ENABLE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BANDWIDTH_SHIFT = 2'd1;

    typedef struct packed {
        logic [1:0]       command;
        logic [31:0]      address;
        logic [3:0]       access_bytes;
        logic [63:0]      write_data;
        logic             debug_access;
        logic [CYC_W-1:0] now_cycle;
    } req_t;

    typedef struct packed {
        logic             status;
        logic [63:0]      read_data;
        logic [CYC_W-1:0] extra_latency;
        logic [3:0]       busy_duration;
    } rsp_t;

    // One write into the data and mark arrays of the memory.
    typedef struct packed {
        logic               en;
        logic [WORD_AW-1:0] addr;
        logic [63:0]        data;
        logic [7:0]         be;
        logic [7:0]         mark_be;
        logic [7:0]         mark_val;
    } mem_wr_t;

endpackage

// ===== rtl/core/checked_sram_with_bandwidth_timing.sv =====
// Top level of the checked byte memory with bandwidth timing.
// Depends on csbt_pkg, csbt_alu (shared adder) and csbt_mem (word memory).
//
// This block is a 64 KiB byte-addressed memory that takes one item at a time:
// a read, a write, a power-off or a power-on, each answered by exactly one
// result item. After reset the block runs a clearing pass over all WORDS
// (8192) words that fills every byte with 0x57 and clears every written mark;
// req_ready stays low during that pass, while configuration writes are taken
// at any time. Power commands and accesses refused for power or size go
// straight from acceptance to the finish step. Every other access has a
// bounds-check step, which is a pass through the shared 48-bit adder, and a
// timed access adds two more adder passes before it (wait, then next free
// cycle). A write that passes the bounds check writes each touched 64-bit
// word in a step of its own, and an access that runs over a word boundary
// touches two words. A read that passes the bounds check takes the same
// steps whatever its alignment: the memory has a single port and a
// registered read, so two word fetches are followed by a check step. The
// slowest item is a timed read. The result sits in an output register, so
// the next item is taken while a finished result still waits on rsp_ready;
// a second finished item holds in its last step until that result is taken.
module checked_sram_with_bandwidth_timing (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_ready,
    input  csbt_pkg::req_t                     req,
    output logic                               rsp_valid,
    input  logic                               rsp_ready,
    output csbt_pkg::rsp_t                     rsp,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [csbt_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [csbt_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // Sequencer state codes.
    localparam logic [3:0] ST_IDLE = 4'd0;
    localparam logic [3:0] ST_T0   = 4'd1;
    localparam logic [3:0] ST_T1   = 4'd2;
    localparam logic [3:0] ST_BND  = 4'd3;
    localparam logic [3:0] ST_WR0  = 4'd4;
    localparam logic [3:0] ST_WR1  = 4'd5;
    localparam logic [3:0] ST_RD0  = 4'd6;
    localparam logic [3:0] ST_RD1  = 4'd7;
    localparam logic [3:0] ST_RD2  = 4'd8;
    localparam logic [3:0] ST_FIN  = 4'd9;

    localparam int CW = csbt_pkg::CYC_W;
    localparam int AW = csbt_pkg::WORD_AW;

    // Mask of the low n bytes, for n from 1 to 8.
    function automatic logic [7:0] low_bytes(input logic [3:0] n);
        logic [8:0] m;
        begin
            m = (9'd1 << n) - 9'd1;
            return m[7:0];
        end
    endfunction

    // Expand a byte mask to a bit mask.
    function automatic logic [63:0] byte_bits(input logic [7:0] m);
        logic [63:0] r;
        begin
            for (int i = 0; i < 8; i++)
            begin
                r[8*i +: 8] = {8{m[i]}};
            end
            return r;
        end
    endfunction

    // Busy duration: max(bytes >> shift, 1).
    function automatic logic [3:0] busy_of(input logic [3:0] n, input logic [2:0] s);
        logic [3:0] d;
        begin
            d = n >> s;
            return (d == 4'd0) ? 4'd1 : d;
        end
    endfunction

    // Control state.
    logic [3:0]    state_reg, state_next;
    logic          clearing_reg, clearing_next;
    logic [AW-1:0] clr_cnt_reg, clr_cnt_next;
    logic          powered_reg, powered_next;
    logic          check_reg, check_next;
    logic [2:0]    shift_reg, shift_next;
    logic [CW-1:0] nfc_reg, nfc_next;
    logic          out_valid_reg, out_valid_next;

    // Item and result payload.
    csbt_pkg::req_t item_reg, item_next;
    csbt_pkg::rsp_t out_reg, out_next;
    logic [CW-1:0]  start_reg, start_next;
    logic [CW-1:0]  extra_reg, extra_next;
    logic [3:0]     busy_reg, busy_next;
    logic           status_reg, status_next;
    logic [63:0]    rdata_reg, rdata_next;
    logic [63:0]    lo_data_reg, lo_data_next;
    logic [7:0]     lo_mark_reg, lo_mark_next;

    // Shared adder and memory hookup.
    logic [CW-1:0] alu_a, alu_b, alu_sum;
    logic          alu_sub, alu_carry;
    csbt_pkg::mem_wr_t mem_wr;
    logic          mem_rd_en;
    logic [AW-1:0] mem_raddr;
    logic [63:0]   mem_rdata;
    logic [7:0]    mem_rmark;

    // Geometry of the latched access.
    logic [2:0]    offset;
    logic [7:0]    n_mask;
    logic [15:0]   win_mask;
    logic [127:0]  win_data;
    logic [AW-1:0] word0, word1;
    logic          crosses;
    logic          out_of_bounds;
    logic [127:0]  rd_window;
    logic [15:0]   mk_window;
    logic          marks_ok;

    csbt_alu u_alu (
        .a     (alu_a),
        .b     (alu_b),
        .sub   (alu_sub),
        .sum   (alu_sum),
        .carry (alu_carry)
    );

    csbt_mem u_mem (
        .clk   (clk),
        .wr    (mem_wr),
        .rd_en (mem_rd_en),
        .raddr (mem_raddr),
        .rdata (mem_rdata),
        .rmark (mem_rmark)
    );

    assign offset   = item_reg.address[2:0];
    assign n_mask   = low_bytes(item_reg.access_bytes);
    assign win_mask = {8'd0, n_mask} << offset;
    assign win_data = {64'd0, item_reg.write_data} << {offset, 3'b000};
    assign word0    = item_reg.address[AW+2:3];
    assign word1    = word0 + {{(AW-1){1'b0}}, 1'b1};
    assign crosses  = (win_mask[15:8] != 8'd0);

    // The adder result in the bounds state is address + bytes.
    assign out_of_bounds = (alu_sum > CW'(csbt_pkg::MEM_BYTES));

    // Read assembly from the two latched words, lowest byte at the offset.
    assign rd_window = {mem_rdata, lo_data_reg} >> {offset, 3'b000};
    assign mk_window = {mem_rmark, lo_mark_reg} >> offset;
    assign marks_ok  = !check_reg || ((mk_window[7:0] & n_mask) == n_mask);

    assign req_ready = (state_reg == ST_IDLE) && !clearing_reg;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;
    assign cfg_ready = 1'b1;

    // Adder operands by step: wait computation, new next free cycle, bounds.
    always_comb
    begin
        case (state_reg)
            ST_T0:
            begin
                alu_a   = nfc_reg;
                alu_b   = item_reg.now_cycle;
                alu_sub = 1'b1;
            end
            ST_T1:
            begin
                alu_a   = start_reg;
                alu_b   = {{(CW-4){1'b0}}, busy_reg};
                alu_sub = 1'b0;
            end
            default:
            begin
                alu_a   = {{(CW-32){1'b0}}, item_reg.address};
                alu_b   = {{(CW-4){1'b0}}, item_reg.access_bytes};
                alu_sub = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        clearing_next  = clearing_reg;
        clr_cnt_next   = clr_cnt_reg;
        powered_next   = powered_reg;
        check_next     = check_reg;
        shift_next     = shift_reg;
        nfc_next       = nfc_reg;
        out_valid_next = out_valid_reg;
        item_next      = item_reg;
        out_next       = out_reg;
        start_next     = start_reg;
        extra_next     = extra_reg;
        busy_next      = busy_reg;
        status_next    = status_reg;
        rdata_next     = rdata_reg;
        lo_data_next   = lo_data_reg;
        lo_mark_next   = lo_mark_reg;
        mem_wr         = '0;
        mem_rd_en      = 1'b0;
        mem_raddr      = word0;

        // Clearing pass: one word per cycle, before any item is taken.
        if (clearing_reg)
        begin
            mem_wr.en       = 1'b1;
            mem_wr.addr     = clr_cnt_reg;
            mem_wr.data     = {8{csbt_pkg::FILL_BYTE}};
            mem_wr.be       = 8'hFF;
            mem_wr.mark_be  = 8'hFF;
            mem_wr.mark_val = 8'h00;
            clr_cnt_next    = clr_cnt_reg + {{(AW-1){1'b0}}, 1'b1};
            if (clr_cnt_reg == AW'(csbt_pkg::WORDS - 1))
            begin
                clearing_next = 1'b0;
            end
        end

        if (out_valid_reg && rsp_ready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid)
        begin
            if (cfg_index == csbt_pkg::REG_CHECK_ENABLE)
            begin
                check_next = cfg_data[0];
            end
            else if (cfg_index == csbt_pkg::REG_BANDWIDTH_SHIFT)
            begin
                shift_next = cfg_data[2:0];
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid && req_ready)
                begin
                    item_next   = req;
                    status_next = 1'b0;
                    rdata_next  = 64'd0;
                    extra_next  = '0;
                    busy_next   = 4'd0;
                    if (req.command == csbt_pkg::CMD_POWER_OFF ||
                        req.command == csbt_pkg::CMD_POWER_ON)
                    begin
                        powered_next = (req.command == csbt_pkg::CMD_POWER_ON);
                        state_next   = ST_FIN;
                    end
                    else if (!powered_reg || req.access_bytes == 4'd0 ||
                             req.access_bytes > 4'(csbt_pkg::MAX_ACCESS_BYTES))
                    begin
                        status_next = 1'b1;
                        state_next  = ST_FIN;
                    end
                    else if (!req.debug_access && shift_reg != 3'd0)
                    begin
                        busy_next  = busy_of(req.access_bytes, shift_reg);
                        state_next = ST_T0;
                    end
                    else
                    begin
                        state_next = ST_BND;
                    end
                end
            end
            ST_T0:
            begin
                // Carry set means the next free cycle is at or after now_cycle,
                // so the item waits for the difference and starts then.
                extra_next = alu_carry ? alu_sum : '0;
                start_next = alu_carry ? nfc_reg : item_reg.now_cycle;
                state_next = ST_T1;
            end
            ST_T1:
            begin
                nfc_next   = alu_sum;
                state_next = ST_BND;
            end
            ST_BND:
            begin
                if (out_of_bounds)
                begin
                    status_next = 1'b1;
                    state_next  = ST_FIN;
                end
                else if (item_reg.command == csbt_pkg::CMD_WRITE)
                begin
                    state_next = ST_WR0;
                end
                else
                begin
                    state_next = ST_RD0;
                end
            end
            ST_WR0:
            begin
                mem_wr.en       = 1'b1;
                mem_wr.addr     = word0;
                mem_wr.data     = win_data[63:0];
                mem_wr.be       = win_mask[7:0];
                mem_wr.mark_be  = check_reg ? win_mask[7:0] : 8'h00;
                mem_wr.mark_val = 8'hFF;
                state_next      = crosses ? ST_WR1 : ST_FIN;
            end
            ST_WR1:
            begin
                mem_wr.en       = 1'b1;
                mem_wr.addr     = word1;
                mem_wr.data     = win_data[127:64];
                mem_wr.be       = win_mask[15:8];
                mem_wr.mark_be  = check_reg ? win_mask[15:8] : 8'h00;
                mem_wr.mark_val = 8'hFF;
                state_next      = ST_FIN;
            end
            ST_RD0:
            begin
                mem_rd_en  = 1'b1;
                mem_raddr  = word0;
                state_next = ST_RD1;
            end
            ST_RD1:
            begin
                lo_data_next = mem_rdata;
                lo_mark_next = mem_rmark;
                mem_rd_en    = 1'b1;
                mem_raddr    = crosses ? word1 : word0;
                state_next   = ST_RD2;
            end
            ST_RD2:
            begin
                if (marks_ok)
                begin
                    rdata_next = rd_window[63:0] & byte_bits(n_mask);
                end
                else
                begin
                    status_next = 1'b1;
                end
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (!out_valid_reg || rsp_ready)
                begin
                    out_next.status        = status_reg;
                    out_next.read_data     = rdata_reg;
                    out_next.extra_latency = extra_reg;
                    out_next.busy_duration = busy_reg;
                    out_valid_next         = 1'b1;
                    state_next             = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            clearing_reg  <= 1'b1;
            clr_cnt_reg   <= '0;
            powered_reg   <= 1'b1;
            check_reg     <= 1'b0;
            shift_reg     <= 3'd0;
            nfc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clearing_reg  <= clearing_next;
            clr_cnt_reg   <= clr_cnt_next;
            powered_reg   <= powered_next;
            check_reg     <= check_next;
            shift_reg     <= shift_next;
            nfc_reg       <= nfc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        out_reg     <= out_next;
        start_reg   <= start_next;
        extra_reg   <= extra_next;
        busy_reg    <= busy_next;
        status_reg  <= status_next;
        rdata_reg   <= rdata_next;
        lo_data_reg <= lo_data_next;
        lo_mark_reg <= lo_mark_next;
    end

endmodule

// ===== rtl/core/csbt_alu.sv =====
// Shared 48-bit adder/subtractor used by the access sequencer.
// Depends on csbt_pkg for the counter width.
module csbt_alu (
    input  logic [csbt_pkg::CYC_W-1:0] a,
    input  logic [csbt_pkg::CYC_W-1:0] b,
    input  logic                       sub,
    output logic [csbt_pkg::CYC_W-1:0] sum,
    output logic                       carry
);

    logic [csbt_pkg::CYC_W-1:0] b_op;

    // With sub set, carry out is high exactly when a >= b.
    assign b_op = sub ? ~b : b;
    assign {carry, sum} = {1'b0, a} + {1'b0, b_op} + {{csbt_pkg::CYC_W{1'b0}}, sub};

endmodule

// ===== rtl/core/csbt_mem.sv =====
// Word memory of the byte store plus the per-byte written marks.
// Depends on csbt_pkg for geometry and the write request type.
module csbt_mem (
    input  logic                          clk,
    input  csbt_pkg::mem_wr_t             wr,
    input  logic                          rd_en,
    input  logic [csbt_pkg::WORD_AW-1:0]  raddr,
    output logic [63:0]                   rdata,
    output logic [7:0]                    rmark
);

    logic [63:0] data_mem [csbt_pkg::WORDS];
    logic [7:0]  mark_mem [csbt_pkg::WORDS];

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 8; i++)
        begin
            if (wr.en && wr.be[i])
            begin
                data_mem[wr.addr][8*i +: 8] <= wr.data[8*i +: 8];
            end
            if (wr.en && wr.mark_be[i])
            begin
                mark_mem[wr.addr][i] <= wr.mark_val[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rdata <= data_mem[raddr];
            rmark <= mark_mem[raddr];
        end
    end

endmodule

// ===== test/tb_checked_sram_with_bandwidth_timing.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for checked_sram_with_bandwidth_timing.
// Depends on csbt_pkg and the block itself. It holds its own model of the
// byte memory and compares every result item with that model.

// Keeps a copy of the memory, the written marks, the timing state and the
// settings. Each accepted item adds its predicted result to a queue, and
// each result from the block is checked against the oldest prediction.
class sram_access_checker;
    logic [7:0]     image [csbt_pkg::MEM_BYTES];
    bit             marked [csbt_pkg::MEM_BYTES];
    logic [47:0]    next_free;
    bit             powered;
    bit             check_on;
    logic [2:0]     bw_shift;
    csbt_pkg::rsp_t pending_results[$];
    int             mismatches;
    int             results_seen;

    function new();
        foreach (image[i])
        begin
            image[i]  = csbt_pkg::FILL_BYTE;
            marked[i] = 1'b0;
        end
        next_free    = '0;
        powered      = 1'b1;
        check_on     = 1'b0;
        bw_shift     = '0;
        mismatches   = 0;
        results_seen = 0;
    endfunction

    function void write_register(logic [csbt_pkg::CFG_IDX_W-1:0] index,
                                 logic [csbt_pkg::CFG_DATA_W-1:0] value);
        if (index == csbt_pkg::REG_CHECK_ENABLE)
            check_on = value[0];
        else if (index == csbt_pkg::REG_BANDWIDTH_SHIFT)
            bw_shift = value;
    endfunction

    // Works out the result of one accepted item and updates the model state.
    function void note_access(csbt_pkg::req_t r);
        csbt_pkg::rsp_t want;
        logic [47:0]    start;
        logic [3:0]     span;
        bit             readable;
        want = '0;
        if (r.command == csbt_pkg::CMD_POWER_OFF || r.command == csbt_pkg::CMD_POWER_ON)
        begin
            powered = (r.command == csbt_pkg::CMD_POWER_ON);
        end
        else if (!powered || r.access_bytes == 0
                 || r.access_bytes > csbt_pkg::MAX_ACCESS_BYTES)
        begin
            want.status = 1'b1;
        end
        else
        begin
            // The timing is charged before the bounds check, so a rejected
            // access still occupies the memory.
            if (!r.debug_access && bw_shift != 0)
            begin
                span = r.access_bytes >> bw_shift;
                if (span == 4'd0)
                    span = 4'd1;
                want.busy_duration = span;
                if (next_free > r.now_cycle)
                    want.extra_latency = next_free - r.now_cycle;
                start     = (next_free > r.now_cycle) ? next_free : r.now_cycle;
                next_free = start + 48'(span);
            end
            if ({32'd0, r.address} + 64'(r.access_bytes) > 64'(csbt_pkg::MEM_BYTES))
            begin
                want.status = 1'b1;
            end
            else if (r.command == csbt_pkg::CMD_WRITE)
            begin
                for (int i = 0; i < r.access_bytes; i++)
                begin
                    image[r.address + i] = r.write_data[8*i +: 8];
                    if (check_on)
                        marked[r.address + i] = 1'b1;
                end
            end
            else
            begin
                readable = 1'b1;
                if (check_on)
                    for (int i = 0; i < r.access_bytes; i++)
                        if (!marked[r.address + i])
                            readable = 1'b0;
                if (!readable)
                    want.status = 1'b1;
                else
                    for (int i = 0; i < r.access_bytes; i++)
                        want.read_data[8*i +: 8] = image[r.address + i];
            end
        end
        pending_results.push_back(want);
    endfunction

    task report_mismatch(string msg);
        $display("MISMATCH at result %0d: %s", results_seen, msg);
        mismatches++;
    endtask

    task check_result(csbt_pkg::rsp_t got);
        csbt_pkg::rsp_t want;
        results_seen++;
        if (pending_results.size() == 0)
        begin
            report_mismatch($sformatf("result %p arrived with no item pending", got));
            return;
        end
        want = pending_results.pop_front();
        if (got.status !== want.status)
            report_mismatch($sformatf("status %b, expected %b", got.status, want.status));
        if (got.read_data !== want.read_data)
            report_mismatch($sformatf("read_data %h, expected %h",
                                      got.read_data, want.read_data));
        if (got.extra_latency !== want.extra_latency)
            report_mismatch($sformatf("extra_latency %h, expected %h",
                                      got.extra_latency, want.extra_latency));
        if (got.busy_duration !== want.busy_duration)
            report_mismatch($sformatf("busy_duration %0d, expected %0d",
                                      got.busy_duration, want.busy_duration));
    endtask
endclass

module tb_checked_sram_with_bandwidth_timing;

    // The slowest correct run is the clearing pass plus about 850 items, each
    // with its longest block sequence, a sender gap and a receiver stall. The
    // limit is several times that.
    localparam int CYCLE_LIMIT     = 300000;
    localparam int DRAIN_CYCLES    = 16;
    localparam int PHASES          = 9;
    localparam int ITEMS_PER_PHASE = 90;

    // Receiver behaviors.
    localparam int RX_OPEN    = 0;
    localparam int RX_RANDOM  = 1;
    localparam int RX_PATTERN = 2;

    logic                            clk       = 1'b0;
    logic                            rst_n     = 1'b0;
    logic                            req_valid = 1'b0;
    logic                            req_ready;
    csbt_pkg::req_t                  req       = '0;
    logic                            rsp_valid;
    logic                            rsp_ready = 1'b0;
    csbt_pkg::rsp_t                  rsp;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [csbt_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [csbt_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    sram_access_checker sb = new();

    // Requester clock carried into now_cycle, and the last well-formed write,
    // which reads often come back to.
    logic [47:0] requester_now = '0;
    logic [31:0] last_wr_addr  = '0;
    logic [3:0]  last_wr_bytes = '0;
    bit          last_wr_valid = 1'b0;

    int          burst_left   = 0;
    int          stall_mode   = RX_OPEN;
    int          stall_left   = 0;
    int          stall_period = 1;
    int          stall_duty   = 1;
    int          stall_phase  = 0;
    int unsigned cycle_count  = 0;

    checked_sram_with_bandwidth_timing dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #6 clk = ~clk;

    // Both handshakes are sampled here, at the edge where they complete. The
    // stimulus changes its signals only by nonblocking assignment, so the
    // values seen here are the ones the block saw at that edge.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_valid && req_ready)
                sb.note_access(req);
            if (rsp_valid && rsp_ready)
                sb.check_result(rsp);
        end
    end

    // The receiver switches every so often between always ready, a coin flip
    // per cycle, and a periodic stall with a random period and duty.
    always @(posedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_mode   = $urandom_range(RX_OPEN, RX_PATTERN);
            stall_left   = $urandom_range(20, 200);
            stall_period = $urandom_range(2, 16);
            stall_duty   = $urandom_range(1, stall_period - 1);
        end
        else
        begin
            stall_left--;
        end
        stall_phase = (stall_phase + 1) % stall_period;
        case (stall_mode)
            RX_OPEN:   rsp_ready <= 1'b1;
            RX_RANDOM: rsp_ready <= ($urandom_range(0, 1) == 1);
            default:   rsp_ready <= (stall_phase < stall_duty);
        endcase
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_checked_sram_with_bandwidth_timing: errors");
            $finish;
        end
    end

    function automatic csbt_pkg::req_t make_item(logic [1:0] command,
                                                 logic [31:0] address,
                                                 logic [3:0] access_bytes,
                                                 logic [63:0] write_data,
                                                 logic debug_access,
                                                 logic [47:0] now_cycle);
        csbt_pkg::req_t r;
        r.command      = command;
        r.address      = address;
        r.access_bytes = access_bytes;
        r.write_data   = write_data;
        r.debug_access = debug_access;
        r.now_cycle    = now_cycle;
        return r;
    endfunction

    // Mostly reads and writes of in-range sizes around a small window, so
    // that reads land on bytes written before; the rest are power commands,
    // bad sizes, accesses near or past the end, and wild addresses.
    function csbt_pkg::req_t random_item();
        csbt_pkg::req_t r;
        int             roll;
        logic [63:0]    wide;
        r = '0;
        wide           = {$urandom, $urandom};
        r.write_data   = {$urandom, $urandom};
        r.debug_access = ($urandom_range(0, 4) == 0);

        roll = $urandom_range(0, 99);
        if (roll < 1)
            r.command = csbt_pkg::CMD_POWER_OFF;
        else if (roll < 8)
            r.command = csbt_pkg::CMD_POWER_ON;
        else if (roll < 54)
            r.command = csbt_pkg::CMD_WRITE;
        else
            r.command = csbt_pkg::CMD_READ;

        roll = $urandom_range(0, 99);
        if (roll < 90)
            r.access_bytes = 4'($urandom_range(1, csbt_pkg::MAX_ACCESS_BYTES));
        else
            r.access_bytes = 4'($urandom_range(0, 15));

        roll = $urandom_range(0, 99);
        if (roll < 55)
            r.address = $urandom_range(0, 95);
        else if (roll < 70)
            r.address = csbt_pkg::MEM_BYTES - 16 + $urandom_range(0, 15);
        else if (roll < 90)
            r.address = $urandom_range(0, csbt_pkg::MEM_BYTES - 1);
        else
            r.address = $urandom;

        // Half the reads go back over the last write, possibly running past
        // its end into bytes that were not written.
        if (r.command == csbt_pkg::CMD_READ && last_wr_valid && $urandom_range(0, 1) == 1)
            r.address = last_wr_addr + $urandom_range(0, int'(last_wr_bytes) - 1);
        if (r.command == csbt_pkg::CMD_WRITE && r.access_bytes >= 1
            && r.access_bytes <= csbt_pkg::MAX_ACCESS_BYTES)
        begin
            last_wr_addr  = r.address;
            last_wr_bytes = r.access_bytes;
            last_wr_valid = 1'b1;
        end

        // The requester clock creeps forward so that waits build up, and now
        // and then jumps anywhere, which also makes it fall behind.
        roll = $urandom_range(0, 99);
        if (roll < 3)
            requester_now = wide[47:0];
        else
            requester_now = requester_now + $urandom_range(0, 3);
        r.now_cycle = requester_now;
        return r;
    endfunction

    // Called at a rising edge. Leaves req_valid high after the handshake, so
    // the next item can follow in the next cycle without a gap.
    task send_item(input csbt_pkg::req_t r);
        req       <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    // The sender works in bursts of random length with random gaps between
    // them; about a quarter of the bursts follow the previous one directly.
    task drive_item(input csbt_pkg::req_t r);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 30);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        send_item(r);
    endtask

    // Writes both registers, the check enable with random upper data bits.
    task apply_settings(input bit check, input logic [2:0] shift);
        logic [csbt_pkg::CFG_DATA_W-1:0] check_word;
        check_word    = csbt_pkg::CFG_DATA_W'($urandom);
        check_word[0] = check;
        cfg_index <= csbt_pkg::REG_CHECK_ENABLE;
        cfg_data  <= check_word;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_register(csbt_pkg::REG_CHECK_ENABLE, check_word);
        cfg_index <= csbt_pkg::REG_BANDWIDTH_SHIFT;
        cfg_data  <= shift;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        sb.write_register(csbt_pkg::REG_BANDWIDTH_SHIFT, shift);
        cfg_valid <= 1'b0;
    endtask

    // Waits one edge first so that the last accepted item has been noted,
    // then until every predicted result has come back.
    task drain_results;
        req_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_results.size() != 0)
            @(posedge clk);
    endtask

    // Runs with checking on and a shift of one, so timing and marks both act.
    task run_directed;
        // A read before any write is refused under checking.
        drive_item(make_item(csbt_pkg::CMD_READ, 32'd0, 4'd8, 64'd0, 1'b0, 48'd0));
        drive_item(make_item(csbt_pkg::CMD_WRITE, 32'd0, 4'd8, '1, 1'b0, 48'd1));
        drive_item(make_item(csbt_pkg::CMD_READ, 32'd0, 4'd8, 64'd0, 1'b1, 48'd2));
        // Only the two low data bytes may land in memory.
        drive_item(make_item(csbt_pkg::CMD_WRITE, 32'd3, 4'd2, 64'h0123_4567_89AB_CDEF,
                             1'b1, 48'd2));
        drive_item(make_item(csbt_pkg::CMD_READ, 32'd0, 4'd8, '1, 1'b0, 48'd3));
        drive_item(make_item(csbt_pkg::CMD_READ, 32'(csbt_pkg::MEM_BYTES - 1), 4'd1,
                             64'd0, 1'b0, 48'd4));
        // The last eight bytes fit exactly; one byte further does not, yet
        // the rejected access is still charged to the timing.
        drive_item(make_item(csbt_pkg::CMD_WRITE, 32'(csbt_pkg::MEM_BYTES - 8), 4'd8,
                             64'h8877_6655_4433_2211, 1'b0, 48'd5));
        drive_item(make_item(csbt_pkg::CMD_READ, 32'(csbt_pkg::MEM_BYTES - 8), 4'd8,
                             64'd0, 1'b0, 48'd5));
        drive_item(make_item(csbt_pkg::CMD_WRITE, 32'(csbt_pkg::MEM_BYTES - 7), 4'd8,
                             '1, 1'b0, 48'd5));
        drive_item(make_item(csbt_pkg::CMD_READ, 32'hFFFF_FFFF, 4'd8, 64'd0, 1'b0, 48'd6));
        // Sizes of zero and above the maximum are refused without timing.
        drive_item(make_item(csbt_pkg::CMD_WRITE, 32'd0, 4'd0, '1, 1'b0, 48'd6));
        drive_item(make_item(csbt_pkg::CMD_READ, 32'd0, 4'd15, 64'd0, 1'b0, 48'd6));
        // While powered down every access is refused and changes nothing.
        drive_item(make_item(csbt_pkg::CMD_POWER_OFF, 32'hFFFF_FFFF, 4'd15, '1, 1'b1, '1));
        drive_item(make_item(csbt_pkg::CMD_READ, 32'd0, 4'd8, 64'd0, 1'b0, 48'd7));
        drive_item(make_item(csbt_pkg::CMD_WRITE, 32'd16, 4'd4, '1, 1'b0, 48'd7));
        drive_item(make_item(csbt_pkg::CMD_POWER_ON, 32'd0, 4'd0, 64'd0, 1'b0, 48'd0));
        drive_item(make_item(csbt_pkg::CMD_READ, 32'd16, 4'd4, 64'd0, 1'b0, 48'd8));
        // Requester clock at its top, then the next free cycle wraps past
        // zero, so a requester back at zero sees a wait.
        drive_item(make_item(csbt_pkg::CMD_READ, 32'd0, 4'd8, 64'd0, 1'b0, '1));
        drive_item(make_item(csbt_pkg::CMD_WRITE, 32'd8, 4'd8, 64'h55AA_55AA_55AA_55AA,
                             1'b0, 48'hFFFF_FFFF_FFFE));
        drive_item(make_item(csbt_pkg::CMD_READ, 32'd8, 4'd8, 64'd0, 1'b0, 48'd0));
        drive_item(make_item(csbt_pkg::CMD_POWER_ON, 32'd0, 4'd1, 64'd0, 1'b0, 48'd0));
    endtask

    // Reset once, then the directed items, then random phases. Settings
    // change only between phases, with nothing in flight; across the phases
    // the shift runs from 0 to 6 and checking is toggled, so marks made with
    // checking on are kept through a phase with checking off.
    initial
    begin
        int p;
        int k;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        apply_settings(1'b1, 3'd1);
        run_directed();
        for (p = 0; p < PHASES; p++)
        begin
            drain_results();
            apply_settings(1'(((p + 1) >> 1) & 1), 3'(p % 7));
            for (k = 0; k < ITEMS_PER_PHASE; k++)
                drive_item(random_item());
        end
        drain_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0)
            $display("tb_checked_sram_with_bandwidth_timing: clean");
        else
            $display("tb_checked_sram_with_bandwidth_timing: errors");
        $finish;
    end
endmodule
